### design/assert_macros.svh
// assertion macros shared by the lock rtl
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// check a condition at every clock edge outside reset
`define A_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("lock assertion failed");
// same-cycle implication
`define A_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lock assertion failed");
// next-cycle implication
`define A_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lock assertion failed");
`else
`define A_ALWAYS(lbl, expr)
`define A_IMPLY(lbl, ante, cons)
`define A_NEXT(lbl, ante, cons)
`endif
`endif

### design/kcl_pkg.sv
// types and constants of the keypad code lock
// no dependencies
package kcl_pkg;

    localparam int CODE_LENGTH = 4;
    localparam int KEY_W       = 8;
    localparam int TRIES_W     = 4;
    localparam int KEYS_OUT_W  = 3;
    localparam int CNT_W       = $clog2(CODE_LENGTH + 1);
    localparam int IDX_W       = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;

    localparam logic [KEY_W-1:0]   NO_KEY         = 8'hff;
    localparam logic [TRIES_W-1:0] MAX_TRIES_RST  = 4'd2;

    localparam logic [1:0] KIND_KEY    = 2'd0;
    localparam logic [1:0] KIND_CHANGE = 2'd1;
    localparam logic [1:0] KIND_CLOSE  = 2'd2;

    typedef enum logic [2:0] {
        MODE_INIT   = 3'd0,
        MODE_ENTRY  = 3'd1,
        MODE_OPEN   = 3'd2,
        MODE_NEWSET = 3'd3,
        MODE_LOCKED = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        ST_TAKEN  = 3'd0,
        ST_STORED = 3'd1,
        ST_OPENED = 3'd2,
        ST_WRONG  = 3'd3,
        ST_LOCKED = 3'd4,
        ST_CLOSED = 3'd5,
        ST_IGNORE = 3'd6
    } t_status;

    typedef struct packed {
        t_status                status;
        logic [TRIES_W-1:0]     tries_left;
        logic [KEYS_OUT_W-1:0]  keys_entered;
        t_mode                  mode;
    } t_result;

endpackage

### design/kcl_skid.sv
// two-entry output buffer for the lock result beats
// depends on kcl_pkg (t_result)
module kcl_skid (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  kcl_pkg::t_result i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output kcl_pkg::t_result o_data
);

    logic             r_out_valid;
    logic             r_skid_valid;
    kcl_pkg::t_result r_out;
    kcl_pkg::t_result r_skid;

    logic             n_out_valid;
    logic             n_skid_valid;
    logic             w_push;
    logic             w_load_out;
    logic             w_load_skid;

    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;
    assign w_push  = i_valid && o_ready;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        w_load_out   = 1'b0;
        w_load_skid  = 1'b0;
        if (!r_out_valid || i_ready) begin
            // output slot frees up: refill from skid first, else from input
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = w_push;
                w_load_out  = w_push;
            end
        end else if (w_push) begin
            n_skid_valid = 1'b1;
            w_load_skid  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid && (!r_out_valid || i_ready)) begin
            r_out <= r_skid;
        end else if (w_load_out) begin
            r_out <= i_data;
        end
        if (w_load_skid) begin
            r_skid <= i_data;
        end
    end

endmodule

### design/keypad_code_lock_top.sv
// keypad code lock: code setup, entry compare, tries and lockout
// depends on kcl_pkg, kcl_skid and assert_macros.svh
//
//  channel  direction  signals                                         beat when
//  in       input      i_in_valid/o_in_ready, i_kind, i_key_code       valid && ready
//  out      output     o_out_valid/i_out_ready, o_status, o_tries_left valid && ready
//                      o_keys_entered, o_mode
//  cfg      input      i_cfg_we, i_cfg_data (max_tries)                i_cfg_we
//
//  one event per cycle while o_in_ready is high: the state update and the
//  four-byte compare are done in the accept cycle, the result is registered
//  in the output buffer; this two-entry buffer keeps accepting while one result
//  waits; o_in_ready drops only when both entries are full
//  synchronous active-low reset: no code stored, initial set mode, tries = 2
//  code and entry bytes have no reset; they are always written before compared
`include "assert_macros.svh"
module keypad_code_lock_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // event channel
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [1:0]                     i_kind,
    input  logic [kcl_pkg::KEY_W-1:0]      i_key_code,
    // result channel
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [2:0]                     o_status,
    output logic [kcl_pkg::TRIES_W-1:0]    o_tries_left,
    output logic [kcl_pkg::KEYS_OUT_W-1:0] o_keys_entered,
    output logic [2:0]                     o_mode,
    // configuration
    input  logic                           i_cfg_we,
    input  logic [kcl_pkg::TRIES_W-1:0]    i_cfg_data
);

    // control state
    logic [kcl_pkg::TRIES_W-1:0] r_max_tries;
    logic [kcl_pkg::TRIES_W-1:0] r_tries;
    logic [kcl_pkg::CNT_W-1:0]   r_key_count;
    kcl_pkg::t_mode              r_mode;

    logic [kcl_pkg::TRIES_W-1:0] n_tries;
    logic [kcl_pkg::CNT_W-1:0]   n_key_count;
    kcl_pkg::t_mode              n_mode;

    // code and entry bytes, written at the current key slot
    logic [kcl_pkg::KEY_W-1:0]   r_code  [kcl_pkg::CODE_LENGTH];
    logic [kcl_pkg::KEY_W-1:0]   r_entry [kcl_pkg::CODE_LENGTH];

    logic                        w_accept;
    logic                        w_buf_ready;
    logic [kcl_pkg::IDX_W-1:0]   w_idx;
    logic                        w_last;
    logic                        w_match;
    logic                        w_code_we;
    logic                        w_entry_we;
    logic [kcl_pkg::TRIES_W-1:0] w_tries_load;
    logic [kcl_pkg::TRIES_W-1:0] w_tries_dec;
    kcl_pkg::t_status            w_status;
    kcl_pkg::t_result            w_result;
    kcl_pkg::t_result            w_out;

    assign o_in_ready = w_buf_ready;
    assign w_accept   = i_in_valid && w_buf_ready;

    // zero max_tries behaves as one
    assign w_tries_load = (r_max_tries == '0) ? kcl_pkg::TRIES_W'(1) : r_max_tries;
    assign w_tries_dec  = (r_tries != '0) ? (r_tries - kcl_pkg::TRIES_W'(1)) : r_tries;

    // slot of this key; an out-of-range count wraps to slot zero
    assign w_idx  = (r_key_count >= kcl_pkg::CNT_W'(kcl_pkg::CODE_LENGTH)) ? '0
                    : kcl_pkg::IDX_W'(r_key_count);
    assign w_last = (w_idx == kcl_pkg::IDX_W'(kcl_pkg::CODE_LENGTH - 1));

    // compare with the key of this beat overlaid on its slot
    always_comb begin
        w_match = 1'b1;
        for (int i = 0; i < kcl_pkg::CODE_LENGTH; i++) begin
            if (kcl_pkg::IDX_W'(i) == w_idx) begin
                if (i_key_code != r_code[i]) w_match = 1'b0;
            end else begin
                if (r_entry[i] != r_code[i]) w_match = 1'b0;
            end
        end
    end

    // next state and status of the event
    always_comb begin
        n_tries     = r_tries;
        n_key_count = r_key_count;
        n_mode      = r_mode;
        w_status    = kcl_pkg::ST_IGNORE;
        w_code_we   = 1'b0;
        w_entry_we  = 1'b0;
        if (r_mode == kcl_pkg::MODE_LOCKED) begin
            w_status = kcl_pkg::ST_LOCKED;
        end else if (i_kind == kcl_pkg::KIND_KEY) begin
            if (i_key_code != kcl_pkg::NO_KEY) begin
                case (r_mode)
                    kcl_pkg::MODE_INIT, kcl_pkg::MODE_NEWSET: begin
                        w_code_we = 1'b1;
                        if (w_last) begin
                            n_key_count = '0;
                            n_mode      = kcl_pkg::MODE_ENTRY;
                            w_status    = kcl_pkg::ST_STORED;
                        end else begin
                            n_key_count = kcl_pkg::CNT_W'(w_idx) + kcl_pkg::CNT_W'(1);
                            w_status    = kcl_pkg::ST_TAKEN;
                        end
                    end
                    kcl_pkg::MODE_ENTRY: begin
                        w_entry_we = 1'b1;
                        if (w_last) begin
                            n_key_count = '0;
                            if (w_match) begin
                                n_mode   = kcl_pkg::MODE_OPEN;
                                w_status = kcl_pkg::ST_OPENED;
                            end else begin
                                n_tries = w_tries_dec;
                                if (w_tries_dec == '0) begin
                                    n_mode   = kcl_pkg::MODE_LOCKED;
                                    w_status = kcl_pkg::ST_LOCKED;
                                end else begin
                                    w_status = kcl_pkg::ST_WRONG;
                                end
                            end
                        end else begin
                            n_key_count = kcl_pkg::CNT_W'(w_idx) + kcl_pkg::CNT_W'(1);
                            w_status    = kcl_pkg::ST_TAKEN;
                        end
                    end
                    default: begin
                        // key while open is ignored
                        w_status = kcl_pkg::ST_IGNORE;
                    end
                endcase
            end
        end else if (r_mode == kcl_pkg::MODE_OPEN && i_kind == kcl_pkg::KIND_CHANGE) begin
            n_tries     = w_tries_load;
            n_key_count = '0;
            n_mode      = kcl_pkg::MODE_NEWSET;
            w_status    = kcl_pkg::ST_TAKEN;
        end else if (r_mode == kcl_pkg::MODE_OPEN && i_kind == kcl_pkg::KIND_CLOSE) begin
            n_tries     = w_tries_load;
            n_key_count = '0;
            n_mode      = kcl_pkg::MODE_ENTRY;
            w_status    = kcl_pkg::ST_CLOSED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_tries <= kcl_pkg::MAX_TRIES_RST;
            r_tries     <= kcl_pkg::MAX_TRIES_RST;
            r_key_count <= '0;
            r_mode      <= kcl_pkg::MODE_INIT;
        end else begin
            if (i_cfg_we) begin
                r_max_tries <= i_cfg_data;
            end
            if (w_accept) begin
                r_tries     <= n_tries;
                r_key_count <= n_key_count;
                r_mode      <= n_mode;
            end
        end
    end

    // byte stores, no reset
    always_ff @(posedge i_clk) begin
        if (w_accept && w_code_we) begin
            r_code[w_idx] <= i_key_code;
        end
        if (w_accept && w_entry_we) begin
            r_entry[w_idx] <= i_key_code;
        end
    end

    assign w_result.status       = w_status;
    assign w_result.tries_left   = n_tries;
    assign w_result.keys_entered = kcl_pkg::KEYS_OUT_W'(n_key_count);
    assign w_result.mode         = n_mode;

    kcl_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .o_ready (w_buf_ready),
        .i_data  (w_result),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (w_out)
    );

    assign o_status       = w_out.status;
    assign o_tries_left   = w_out.tries_left;
    assign o_keys_entered = w_out.keys_entered;
    assign o_mode         = w_out.mode;

    // lockout is permanent until reset
    `A_NEXT(a_lock_sticks, r_mode == kcl_pkg::MODE_LOCKED, r_mode == kcl_pkg::MODE_LOCKED)
    // key count never reaches the code length
    `A_ALWAYS(a_count_range, r_key_count < kcl_pkg::CNT_W'(kcl_pkg::CODE_LENGTH))
    // tries run out only together with the lockout
    `A_IMPLY(a_tries_live, r_mode != kcl_pkg::MODE_LOCKED, r_tries != '0)
    // a locked-out result always reports locked mode
    `A_IMPLY(a_locked_result, o_out_valid && o_status == kcl_pkg::ST_LOCKED,
             o_mode == kcl_pkg::MODE_LOCKED)

endmodule

### tb/keypad_code_lock_top_test.sv
// self-checking testbench for keypad_code_lock_top: directed and random event beats,
// checked against an in-bench model of the lock held in a small scoreboard class
// depends on kcl_pkg and keypad_code_lock_top
module keypad_code_lock_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    // the one kind code the package leaves unnamed, always ignored by the lock
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam int PHASES         = 8;
    localparam int PHASE_EVENTS   = 230;
    localparam int HOLD_CYCLES    = 120;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 8;
    localparam int MAX_REPORTS    = 10;

    // model of the lock plus the queue of results still owed by the block
    class lock_scoreboard;
        logic [kcl_pkg::TRIES_W-1:0] max_tries;
        logic [kcl_pkg::KEY_W-1:0]   code  [kcl_pkg::CODE_LENGTH];
        logic [kcl_pkg::KEY_W-1:0]   entry [kcl_pkg::CODE_LENGTH];
        int                          key_count;
        logic [kcl_pkg::TRIES_W-1:0] tries;
        kcl_pkg::t_mode              mode;
        kcl_pkg::t_result            owed_q[$];
        int                          failures;

        function new();
            max_tries = kcl_pkg::MAX_TRIES_RST;
            foreach (code[i]) begin
                code[i]  = '0;
                entry[i] = '0;
            end
            key_count = 0;
            tries     = kcl_pkg::MAX_TRIES_RST;
            mode      = kcl_pkg::MODE_INIT;
            failures  = 0;
        endfunction

        function void set_max_tries(logic [kcl_pkg::TRIES_W-1:0] value);
            max_tries = value;
        endfunction

        // zero in the register still grants one try
        function logic [kcl_pkg::TRIES_W-1:0] tries_reload();
            return (max_tries == '0) ? kcl_pkg::TRIES_W'(1) : max_tries;
        endfunction

        function kcl_pkg::t_result lock_step(logic [1:0] kind,
                                             logic [kcl_pkg::KEY_W-1:0] key);
            kcl_pkg::t_status st;
            kcl_pkg::t_result r;
            int               idx;
            bit               same;
            st = kcl_pkg::ST_IGNORE;
            if (mode == kcl_pkg::MODE_LOCKED) begin
                st = kcl_pkg::ST_LOCKED;
            end else if (kind == kcl_pkg::KIND_KEY) begin
                if (key != kcl_pkg::NO_KEY) begin
                    idx = (key_count >= kcl_pkg::CODE_LENGTH) ? 0 : key_count;
                    if (mode == kcl_pkg::MODE_INIT || mode == kcl_pkg::MODE_NEWSET) begin
                        code[idx] = key;
                        key_count = idx + 1;
                        st = kcl_pkg::ST_TAKEN;
                        if (key_count >= kcl_pkg::CODE_LENGTH) begin
                            key_count = 0;
                            mode = kcl_pkg::MODE_ENTRY;
                            st = kcl_pkg::ST_STORED;
                        end
                    end else if (mode == kcl_pkg::MODE_ENTRY) begin
                        entry[idx] = key;
                        key_count = idx + 1;
                        st = kcl_pkg::ST_TAKEN;
                        if (key_count >= kcl_pkg::CODE_LENGTH) begin
                            key_count = 0;
                            same = 1'b1;
                            foreach (code[i])
                                if (entry[i] != code[i]) same = 1'b0;
                            if (same) begin
                                mode = kcl_pkg::MODE_OPEN;
                                st = kcl_pkg::ST_OPENED;
                            end else begin
                                if (tries != '0) tries = tries - 1'b1;
                                if (tries == '0) begin
                                    mode = kcl_pkg::MODE_LOCKED;
                                    st = kcl_pkg::ST_LOCKED;
                                end else begin
                                    st = kcl_pkg::ST_WRONG;
                                end
                            end
                        end
                    end
                end
            end else if (mode == kcl_pkg::MODE_OPEN && kind == kcl_pkg::KIND_CHANGE) begin
                tries = tries_reload();
                key_count = 0;
                mode = kcl_pkg::MODE_NEWSET;
                st = kcl_pkg::ST_TAKEN;
            end else if (mode == kcl_pkg::MODE_OPEN && kind == kcl_pkg::KIND_CLOSE) begin
                tries = tries_reload();
                key_count = 0;
                mode = kcl_pkg::MODE_ENTRY;
                st = kcl_pkg::ST_CLOSED;
            end
            r.status       = st;
            r.tries_left   = tries;
            r.keys_entered = kcl_pkg::KEYS_OUT_W'(key_count);
            r.mode         = mode;
            return r;
        endfunction

        function void note_event(logic [1:0] kind, logic [kcl_pkg::KEY_W-1:0] key);
            owed_q.push_back(lock_step(kind, key));
        endfunction

        function void check_result(kcl_pkg::t_result got);
            kcl_pkg::t_result want;
            if (owed_q.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("%0t: result beat with nothing owed: status %0d mode %0d",
                             $time, got.status, got.mode);
                return;
            end
            want = owed_q.pop_front();
            if (got.status !== want.status || got.tries_left !== want.tries_left ||
                got.keys_entered !== want.keys_entered || got.mode !== want.mode) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display({"%0t: mismatch status %0d/%0d tries %0d/%0d",
                              " keys %0d/%0d mode %0d/%0d (exp/got)"},
                             $time, want.status, got.status, want.tries_left, got.tries_left,
                             want.keys_entered, got.keys_entered, want.mode, got.mode);
            end
        endfunction
    endclass

    typedef enum int {RX_OPEN, RX_COIN, RX_PERIODIC, RX_SPARSE} t_rx_style;

    logic                           i_clk          = 1'b0;
    logic                           i_rst_n        = 1'b0;
    logic                           i_in_valid     = 1'b0;
    logic                           o_in_ready;
    logic [1:0]                     i_kind         = kcl_pkg::KIND_KEY;
    logic [kcl_pkg::KEY_W-1:0]      i_key_code     = '0;
    logic                           o_out_valid;
    logic                           i_out_ready    = 1'b0;
    logic [2:0]                     o_status;
    logic [kcl_pkg::TRIES_W-1:0]    o_tries_left;
    logic [kcl_pkg::KEYS_OUT_W-1:0] o_keys_entered;
    logic [2:0]                     o_mode;
    logic                           i_cfg_we       = 1'b0;
    logic [kcl_pkg::TRIES_W-1:0]    i_cfg_data     = '0;

    lock_scoreboard sb;       // checks the result beats
    lock_scoreboard plan;     // runs at stimulus time so the stimulus can follow the lock
    // keys of the entry attempt in progress
    logic [kcl_pkg::KEY_W-1:0] attempt [kcl_pkg::CODE_LENGTH];
    logic [kcl_pkg::TRIES_W-1:0] try_settings [PHASES] =
        '{4'd15, 4'd1, 4'd0, 4'd9, 4'd4, 4'd15, 4'd2, 4'd3};

    int events_sent  = 0;     // input beats, counted by the sender
    int results_seen = 0;     // output beats, counted by the monitor
    int burst_left   = 0;
    int idle_cycles  = 0;
    bit hold_req     = 1'b0;  // asks the receiver for one long hold-off
    bit wrap_up      = 1'b0;  // final phase: drive the lock into lockout

    keypad_code_lock_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_kind         (i_kind),
        .i_key_code     (i_key_code),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_tries_left   (o_tries_left),
        .o_keys_entered (o_keys_entered),
        .o_mode         (o_mode),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // all tb inputs change by nonblocking assignment, so this block sees the
    // values from before the edge: a beat here is exactly what the block took
    always @(posedge i_clk) begin : watch_beats
        kcl_pkg::t_result got;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                sb.note_event(i_kind, i_key_code);
            if (o_out_valid && i_out_ready) begin
                got.status       = kcl_pkg::t_status'(o_status);
                got.tries_left   = o_tries_left;
                got.keys_entered = o_keys_entered;
                got.mode         = kcl_pkg::t_mode'(o_mode);
                sb.check_result(got);
                results_seen++;
            end
            // watchdog: no beat on either side for too long means a hang
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // receiver: a random stall style per window, plus a long hold-off on request
    initial begin : drive_out_ready
        t_rx_style style;
        int        left;
        style = RX_OPEN;
        left  = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                // the sender keeps offering, so the two-entry buffer fills and
                // o_in_ready has to drop
                hold_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                if (left == 0) begin
                    style = t_rx_style'($urandom_range(0, 3));
                    left  = $urandom_range(16, 96);
                end
                left--;
                case (style)
                    RX_OPEN:     i_out_ready <= 1'b1;
                    RX_COIN:     i_out_ready <= ($urandom_range(0, 1) == 1);
                    RX_PERIODIC: i_out_ready <= (left % 4 != 0);
                    default:     i_out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // one event beat; bursts of back-to-back beats with random gaps between them
    task automatic send_event(input logic [1:0] kind, input logic [kcl_pkg::KEY_W-1:0] key);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 12);
            burst_left = $urandom_range(1, 40);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        burst_left--;
        void'(plan.lock_step(kind, key));
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_key_code <= key;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        events_sent++;
    endtask

    // drop valid and wait until every owed result has come back
    task automatic drain_lock();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (results_seen < events_sent) @(posedge i_clk);
    endtask

    // register writes only with the lock idle; the new value shows at the next reload
    task automatic write_max_tries(input logic [kcl_pkg::TRIES_W-1:0] value);
        drain_lock();
        repeat (2) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_max_tries(value);
        plan.set_max_tries(value);
    endtask

    // new entry attempt: mostly the stored code, sometimes one or more bytes off,
    // but never a wrong one on the last try unless the run is winding down
    task automatic choose_attempt();
        int j;
        logic [kcl_pkg::KEY_W-1:0] v;
        attempt = plan.code;
        if (wrap_up || (plan.tries > 1 && $urandom_range(0, 99) < 35)) begin
            j = $urandom_range(0, kcl_pkg::CODE_LENGTH - 1);
            do v = kcl_pkg::KEY_W'($urandom_range(0, 254)); while (v == plan.code[j]);
            attempt[j] = v;
            foreach (attempt[i])
                if (i != j && $urandom_range(0, 3) == 0)
                    attempt[i] = kcl_pkg::KEY_W'($urandom_range(0, 254));
        end
    endtask

    // next event, following the planned lock state
    task automatic pick_event(output logic [1:0] kind,
                              output logic [kcl_pkg::KEY_W-1:0] key);
        kind = kcl_pkg::KIND_KEY;
        key  = kcl_pkg::KEY_W'($urandom_range(0, 255));
        if (plan.mode == kcl_pkg::MODE_LOCKED) begin
            kind = 2'($urandom_range(0, 3));
        end else if ($urandom_range(0, 9) == 0) begin
            // noise: empty key, unused kind, or a beat the current mode ignores
            case ($urandom_range(0, 2))
                0:       key = kcl_pkg::NO_KEY;
                1:       kind = KIND_UNUSED;
                default: if (plan.mode != kcl_pkg::MODE_OPEN) kind = 2'($urandom_range(1, 2));
            endcase
        end else begin
            case (plan.mode)
                kcl_pkg::MODE_INIT, kcl_pkg::MODE_NEWSET:
                    key = kcl_pkg::KEY_W'($urandom_range(0, 254));
                kcl_pkg::MODE_ENTRY: begin
                    if (plan.key_count == 0) choose_attempt();
                    key = attempt[plan.key_count];
                end
                default:
                    kind = (wrap_up || $urandom_range(0, 1) == 1) ? kcl_pkg::KIND_CLOSE
                                                                  : kcl_pkg::KIND_CHANGE;
            endcase
        end
    endtask

    initial begin : stimulus
        logic [1:0]                kind;
        logic [kcl_pkg::KEY_W-1:0] key;
        int                        extra;
        sb   = new();
        plan = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // no code stored yet: empty key, both buttons and the unused kind are ignored
        send_event(kcl_pkg::KIND_KEY, kcl_pkg::NO_KEY);
        send_event(kcl_pkg::KIND_CHANGE, 8'h00);
        send_event(kcl_pkg::KIND_CLOSE, 8'hff);
        send_event(KIND_UNUSED, 8'h5a);
        // first code: key extremes and the digit characters
        send_event(kcl_pkg::KIND_KEY, 8'h00);
        send_event(kcl_pkg::KIND_KEY, 8'hfe);
        send_event(kcl_pkg::KIND_KEY, 8'h30);
        send_event(kcl_pkg::KIND_KEY, 8'h31);
        // wrong entry with an empty key in the middle, costs one of the two tries
        send_event(kcl_pkg::KIND_KEY, 8'h00);
        send_event(kcl_pkg::KIND_KEY, 8'hfe);
        send_event(kcl_pkg::KIND_KEY, kcl_pkg::NO_KEY);
        send_event(kcl_pkg::KIND_KEY, 8'h30);
        send_event(kcl_pkg::KIND_KEY, 8'h30);
        // button outside open mode
        send_event(kcl_pkg::KIND_CHANGE, 8'h00);
        // right code opens
        send_event(kcl_pkg::KIND_KEY, 8'h00);
        send_event(kcl_pkg::KIND_KEY, 8'hfe);
        send_event(kcl_pkg::KIND_KEY, 8'h30);
        send_event(kcl_pkg::KIND_KEY, 8'h31);
        // key press while open is ignored, close restores the tries
        send_event(kcl_pkg::KIND_KEY, 8'h31);
        send_event(kcl_pkg::KIND_CLOSE, 8'h00);
        send_event(kcl_pkg::KIND_KEY, 8'h00);
        send_event(kcl_pkg::KIND_KEY, 8'hfe);
        send_event(kcl_pkg::KIND_KEY, 8'h30);
        send_event(kcl_pkg::KIND_KEY, 8'h31);
        // change button: new code keys follow in the random part
        send_event(kcl_pkg::KIND_CHANGE, 8'hff);

        // random phases, one try setting each (zero and both ends among them)
        for (int p = 0; p < PHASES; p++) begin
            write_max_tries((p == 6) ? kcl_pkg::TRIES_W'($urandom_range(1, 15))
                                     : try_settings[p]);
            for (int n = 0; n < PHASE_EVENTS; n++) begin
                if (p % 2 == 1 && n == PHASE_EVENTS / 2)
                    hold_req = 1'b1;
                if (p == 2 && n == PHASE_EVENTS / 3)
                    drain_lock();
                pick_event(kind, key);
                send_event(kind, key);
            end
        end

        // lockout is permanent, so it comes last: wrong codes until locked,
        // then twelve beats of random kinds against the locked lock
        wrap_up = 1'b1;
        extra = 0;
        while (extra < 12) begin
            if (plan.mode == kcl_pkg::MODE_LOCKED) extra++;
            pick_event(kind, key);
            send_event(kind, key);
        end

        drain_lock();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.failures == 0 && sb.owed_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            if (sb.owed_q.size() != 0)
                $display("%0d owed results never came back", sb.owed_q.size());
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
